// ===== rtl/core/tbt_pkg.sv =====
// ----------------------------------------------------------------------------
// tbt_pkg
// types and codes shared by the token bucket table
// ----------------------------------------------------------------------------
package tbt_pkg;

    localparam int SLOT_W = 4;
    localparam int TOK_W  = 16;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FETCH   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOSLOT = 2'd1,
        ST_SHORT  = 2'd2,
        ST_FREE   = 2'd3
    } t_status;

    typedef enum logic {
        ALU_SUB     = 1'b0,
        ALU_ADD_SAT = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic             lacking;
        logic [TOK_W-1:0] res;
    } t_alu_out;

endpackage

// ===== rtl/core/tbt_ifs.sv =====
// ----------------------------------------------------------------------------
// tbt_req_if / tbt_rsp_if
// request and response channels of the token bucket table
// ----------------------------------------------------------------------------
interface tbt_req_if;
    import tbt_pkg::*;

    logic              valid;
    logic              ready;
    t_cmd              cmd;
    logic [SLOT_W-1:0] slot;
    logic [TOK_W-1:0]  amount;
    logic [TOK_W-1:0]  rate;
    logic [TOK_W-1:0]  limit;

    modport source (output valid, cmd, slot, amount, rate, limit, input ready);
    modport sink   (input valid, cmd, slot, amount, rate, limit, output ready);
endinterface

interface tbt_rsp_if;
    import tbt_pkg::*;

    logic              valid;
    logic              ready;
    t_status           status;
    logic [SLOT_W-1:0] slot_out;
    logic [TOK_W-1:0]  tokens_left;

    modport source (output valid, status, slot_out, tokens_left, input ready);
    modport sink   (input valid, status, slot_out, tokens_left, output ready);
endinterface

// ===== rtl/core/tbt_alu.sv =====
// ----------------------------------------------------------------------------
// tbt_alu
// shared token arithmetic: subtract with borrow, or add saturating at a ceiling
// ----------------------------------------------------------------------------
module tbt_alu (
    input  tbt_pkg::t_alu_op                i_op,
    input  logic [tbt_pkg::TOK_W-1:0]       i_a,
    input  logic [tbt_pkg::TOK_W-1:0]       i_b,
    input  logic [tbt_pkg::TOK_W-1:0]       i_ceil,
    output tbt_pkg::t_alu_out               o_res
);
    import tbt_pkg::*;

    logic [TOK_W:0] w_sum;
    logic [TOK_W:0] w_diff;

    assign w_sum  = {1'b0, i_a} + {1'b0, i_b};
    assign w_diff = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        unique case (i_op)
            ALU_SUB: begin
                o_res.lacking = w_diff[TOK_W];
                o_res.res     = w_diff[TOK_W-1:0];
            end
            ALU_ADD_SAT: begin
                o_res.lacking = 1'b0;
                if (w_sum > {1'b0, i_ceil}) begin
                    o_res.res = i_ceil;
                end else begin
                    o_res.res = w_sum[TOK_W-1:0];
                end
            end
            default: begin
                o_res.lacking = 1'b0;
                o_res.res     = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/token_bucket_table_top.sv =====
// ----------------------------------------------------------------------------
// token_bucket_table_top
// table of token buckets with allocate, fetch, release and refill tick
// ----------------------------------------------------------------------------
// One word is taken at a time; ready stays low until its response has been
// loaded into the output register. Allocate, fetch and release go through
// the execute state, then the output state, which waits for a free output
// register; a tick walks every slot through the single token adder, one slot
// per cycle, reading tokens, rate and limit from their memories, then goes to
// the output state. A fetch that finds too few tokens leaves the slot
// unchanged and reports status 2. No clearing pass is needed after reset.
module token_bucket_table_top #(
    parameter int SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tbt_req_if.sink      i_req,
    tbt_rsp_if.source    o_rsp
);
    import tbt_pkg::*;

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NSRCH = (SLOTS < 16) ? SLOTS : 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [SLOTS-1:0]  r_live;
    logic [SW-1:0]     r_idx;

    t_cmd              r_cmd;
    logic [SLOT_W-1:0] r_slot;
    logic [TOK_W-1:0]  r_amount;
    logic [TOK_W-1:0]  r_rate;
    logic [TOK_W-1:0]  r_limit;

    t_status           r_res_status;
    logic [SLOT_W-1:0] r_res_slot;
    logic [TOK_W-1:0]  r_res_left;

    logic              r_rsp_valid;
    t_status           r_rsp_status;
    logic [SLOT_W-1:0] r_rsp_slot;
    logic [TOK_W-1:0]  r_rsp_left;

    logic [TOK_W-1:0]  r_tok_mem  [SLOTS];
    logic [TOK_W-1:0]  r_rate_mem [SLOTS];
    logic [TOK_W-1:0]  r_lim_mem  [SLOTS];
    logic [TOK_W-1:0]  r_tok_q;
    logic [TOK_W-1:0]  r_rate_q;
    logic [TOK_W-1:0]  r_lim_q;

    logic              w_accept;
    logic [SW-1:0]     w_raddr;
    logic [SW-1:0]     w_slot_idx;
    logic              w_slot_live;
    logic              w_free_found;
    logic [SW-1:0]     w_free_idx;
    logic              w_tok_we;
    logic [SW-1:0]     w_tok_waddr;
    logic [TOK_W-1:0]  w_tok_wdata;
    logic              w_cfg_we;
    logic              w_out_free;
    logic              w_cur_live;
    logic              w_last;
    logic              w_hit;
    t_alu_op           w_alu_op;
    t_alu_out          w_alu;

    assign i_req.ready       = (r_state == S_IDLE) && i_rst_n;
    assign w_accept          = i_req.valid && i_req.ready;
    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_rsp_status;
    assign o_rsp.slot_out    = r_rsp_slot;
    assign o_rsp.tokens_left = r_rsp_left;

    assign w_slot_idx  = SW'(r_slot);
    assign w_slot_live = ({28'd0, r_slot} < 32'(SLOTS)) && r_live[w_slot_idx];
    assign w_cur_live  = r_live[r_idx];
    assign w_last      = (r_idx == SW'(SLOTS - 1));
    assign w_hit       = (32'(r_idx) == {28'd0, r_slot});
    assign w_out_free  = !r_rsp_valid || o_rsp.ready;
    assign w_alu_op    = (r_state == S_TICK) ? ALU_ADD_SAT : ALU_SUB;

    // lowest free slot among those the slot field can name
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = NSRCH - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = SW'(i);
            end
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = (i_req.cmd == CMD_TICK) ? '0 : SW'(i_req.slot);
            S_TICK:  w_raddr = r_idx + SW'(1);
            default: w_raddr = r_idx;
        endcase
    end

    always_comb begin
        w_tok_we    = 1'b0;
        w_tok_waddr = w_slot_idx;
        w_tok_wdata = w_alu.res;
        w_cfg_we    = 1'b0;
        unique case (r_state)
            S_EXEC: begin
                if (r_cmd == CMD_ALLOC && w_free_found) begin
                    w_tok_we    = 1'b1;
                    w_tok_waddr = w_free_idx;
                    w_tok_wdata = '0;
                    w_cfg_we    = 1'b1;
                end else if (r_cmd == CMD_FETCH && w_slot_live && !w_alu.lacking) begin
                    w_tok_we = 1'b1;
                end
            end
            S_TICK: begin
                w_tok_we    = w_cur_live;
                w_tok_waddr = r_idx;
            end
            default: begin
                w_tok_we = 1'b0;
            end
        endcase
    end

    tbt_alu u_alu (
        .i_op   (w_alu_op),
        .i_a    (r_tok_q),
        .i_b    ((r_state == S_TICK) ? r_rate_q : r_amount),
        .i_ceil (r_lim_q),
        .o_res  (w_alu)
    );

    always_ff @(posedge i_clk) begin
        if (w_tok_we) begin
            r_tok_mem[w_tok_waddr] <= w_tok_wdata;
        end
        if (w_cfg_we) begin
            r_rate_mem[w_free_idx] <= r_rate;
            r_lim_mem[w_free_idx]  <= r_limit;
        end
        r_tok_q  <= r_tok_mem[w_raddr];
        r_rate_q <= r_rate_mem[w_raddr];
        r_lim_q  <= r_lim_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_rsp_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (o_rsp.ready && r_state != S_OUT) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd      <= i_req.cmd;
                        r_slot     <= i_req.slot;
                        r_amount   <= i_req.amount;
                        r_rate     <= i_req.rate;
                        r_limit    <= i_req.limit;
                        r_idx      <= '0;
                        r_res_left <= '0;
                        r_state    <= (i_req.cmd == CMD_TICK) ? S_TICK : S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_cmd)
                        CMD_ALLOC: begin
                            r_res_left <= '0;
                            if (w_free_found) begin
                                r_live[w_free_idx] <= 1'b1;
                                r_res_status       <= ST_OK;
                                r_res_slot         <= SLOT_W'(w_free_idx);
                            end else begin
                                r_res_status <= ST_NOSLOT;
                                r_res_slot   <= '0;
                            end
                        end
                        CMD_FETCH: begin
                            r_res_slot <= r_slot;
                            if (!w_slot_live) begin
                                r_res_status <= ST_FREE;
                                r_res_left   <= '0;
                            end else if (w_alu.lacking) begin
                                r_res_status <= ST_SHORT;
                                r_res_left   <= r_tok_q;
                            end else begin
                                r_res_status <= ST_OK;
                                r_res_left   <= w_alu.res;
                            end
                        end
                        CMD_RELEASE: begin
                            r_res_slot <= r_slot;
                            r_res_left <= '0;
                            if (!w_slot_live) begin
                                r_res_status <= ST_FREE;
                            end else begin
                                r_res_status       <= ST_OK;
                                r_live[w_slot_idx] <= 1'b0;
                            end
                        end
                        default: begin
                            r_res_status <= ST_OK;
                            r_res_slot   <= r_slot;
                            r_res_left   <= '0;
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_TICK: begin
                    if (w_hit && w_cur_live) begin
                        r_res_left <= w_alu.res;
                    end
                    if (w_last) begin
                        r_res_status <= ST_OK;
                        r_res_slot   <= r_slot;
                        r_state      <= S_OUT;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_rsp_valid  <= 1'b1;
                        r_rsp_status <= r_res_status;
                        r_rsp_slot   <= r_res_slot;
                        r_rsp_left   <= r_res_left;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_rsp_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state) == S_OUT)
        else $error("response raised outside output state");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("ready high right after accepting a word");

    a_noslot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_NOSLOT) |->
            (o_rsp.slot_out == '0 && o_rsp.tokens_left == '0))
        else $error("failed allocate reports nonzero slot or tokens");

    a_tick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> (32'(r_idx) < 32'(SLOTS)))
        else $error("tick scan index beyond table");

endmodule

// ===== test/token_bucket_table_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_bucket_table_top_test
// self-checking bench for the token bucket table: a directed table of words
// (reset state, allocate until full, short and zero fetches, saturating ticks,
// release of live and free slots) followed by mostly well-formed random
// traffic. Each reply is checked against its table row or a bucket predictor,
// under random idling on both channels, one long reply stall and drain pauses.
// ----------------------------------------------------------------------------
module token_bucket_table_top_test;
    import tbt_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_WORDS = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int TICK_CYCLES  = SLOTS + 2;

    typedef struct {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [TOK_W-1:0]  tokens;
    } t_reply;

    typedef struct {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot;
        logic [TOK_W-1:0]  amount;
        logic [TOK_W-1:0]  rate;
        logic [TOK_W-1:0]  limit;
        bit                typed;
        t_reply            want;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tbt_req_if req_if ();
    tbt_rsp_if rsp_if ();

    token_bucket_table_top #(
        .SLOTS (SLOTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted table contents
    bit               bkt_live   [SLOTS];
    logic [TOK_W-1:0] bkt_tokens [SLOTS];
    logic [TOK_W-1:0] bkt_rate   [SLOTS];
    logic [TOK_W-1:0] bkt_limit  [SLOTS];

    t_reply replies_due[$];
    t_reply row_want;
    bit     row_typed     = 1'b0;
    int     mismatches    = 0;
    int     tx_idle_pct   = 20;
    int     rx_idle_pct   = 71;
    int     holds_asked   = 0;
    int     holds_done    = 0;
    int     hold_left     = 0;

    initial begin
        foreach (bkt_live[i]) begin
            bkt_live[i]   = 1'b0;
            bkt_tokens[i] = '0;
            bkt_rate[i]   = '0;
            bkt_limit[i]  = '0;
        end
    end

    function automatic bit slot_in_use(logic [SLOT_W-1:0] slot);
        return int'(slot) < SLOTS && bkt_live[slot];
    endfunction

    function automatic t_reply bucket_table_step(t_cmd cmd, logic [SLOT_W-1:0] slot,
                                                 logic [TOK_W-1:0] amount,
                                                 logic [TOK_W-1:0] rate,
                                                 logic [TOK_W-1:0] limit);
        t_reply       r;
        int           n;
        int           free_idx;
        logic [TOK_W:0] sum;
        r.status = ST_OK;
        r.slot   = slot;
        r.tokens = '0;
        n        = SLOTS < 16 ? SLOTS : 16;
        free_idx = -1;
        case (cmd)
            CMD_ALLOC: begin
                for (int i = n - 1; i >= 0; i--)
                    if (!bkt_live[i]) free_idx = i;
                if (free_idx < 0) begin
                    r.status = ST_NOSLOT;
                    r.slot   = '0;
                end else begin
                    bkt_live[free_idx]   = 1'b1;
                    bkt_tokens[free_idx] = '0;
                    bkt_rate[free_idx]   = rate;
                    bkt_limit[free_idx]  = limit;
                    r.slot               = SLOT_W'(free_idx);
                end
            end
            CMD_FETCH: begin
                if (!slot_in_use(slot)) begin
                    r.status = ST_FREE;
                end else if (bkt_tokens[slot] < amount) begin
                    r.status = ST_SHORT;
                    r.tokens = bkt_tokens[slot];
                end else begin
                    bkt_tokens[slot] = bkt_tokens[slot] - amount;
                    r.tokens         = bkt_tokens[slot];
                end
            end
            CMD_RELEASE: begin
                if (!slot_in_use(slot)) begin
                    r.status = ST_FREE;
                end else begin
                    bkt_live[slot]   = 1'b0;
                    bkt_tokens[slot] = '0;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (bkt_live[i]) begin
                        sum = {1'b0, bkt_tokens[i]} + {1'b0, bkt_rate[i]};
                        if (sum > {1'b0, bkt_limit[i]}) sum = {1'b0, bkt_limit[i]};
                        bkt_tokens[i] = sum[TOK_W-1:0];
                    end
                end
                if (slot_in_use(slot)) r.tokens = bkt_tokens[slot];
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // request and reply monitor
    always @(posedge i_clk) begin : watch_channels
        t_reply predicted;
        t_reply want;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predicted = bucket_table_step(req_if.cmd, req_if.slot, req_if.amount,
                                          req_if.rate, req_if.limit);
            replies_due.push_back(row_typed ? row_want : predicted);
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("reply with none due, status %0d slot %0d tokens %0d",
                                          rsp_if.status, rsp_if.slot_out, rsp_if.tokens_left));
            end else begin
                want = replies_due.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp_if.status, want.status));
                if (rsp_if.slot_out !== want.slot)
                    report_mismatch($sformatf("slot_out got %0d want %0d",
                                              rsp_if.slot_out, want.slot));
                if (rsp_if.tokens_left !== want.tokens)
                    report_mismatch($sformatf("tokens_left got %0d want %0d",
                                              rsp_if.tokens_left, want.tokens));
            end
        end
    end

    // reply side: random ready, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (holds_asked != holds_done) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_done   <= holds_done + 1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic t_stim_row stim_row(t_cmd cmd, logic [SLOT_W-1:0] slot,
                                           logic [TOK_W-1:0] amount,
                                           logic [TOK_W-1:0] rate,
                                           logic [TOK_W-1:0] limit, bit typed,
                                           t_status status, logic [SLOT_W-1:0] slot_out,
                                           logic [TOK_W-1:0] tokens);
        t_stim_row w;
        w.cmd         = cmd;
        w.slot        = slot;
        w.amount      = amount;
        w.rate        = rate;
        w.limit       = limit;
        w.typed       = typed;
        w.want.status = status;
        w.want.slot   = slot_out;
        w.want.tokens = tokens;
        return w;
    endfunction

    function automatic t_stim_row random_word();
        t_stim_row w;
        int        pick;
        int        live_cnt;
        int        nth;
        int        held;
        w = stim_row(t_cmd'($urandom_range(3)), SLOT_W'($urandom), TOK_W'($urandom),
                     TOK_W'($urandom), TOK_W'($urandom), 1'b0, ST_OK, '0, '0);
        // noise
        if ($urandom_range(99) < 10) return w;
        pick  = $urandom_range(99);
        w.cmd = pick < 20 ? CMD_ALLOC : pick < 60 ? CMD_FETCH : pick < 75 ? CMD_RELEASE
                                                                          : CMD_TICK;
        live_cnt = 0;
        foreach (bkt_live[i]) live_cnt += bkt_live[i];
        if (live_cnt != 0 && $urandom_range(99) < 85) begin
            nth = $urandom_range(live_cnt - 1);
            foreach (bkt_live[i]) begin
                if (bkt_live[i]) begin
                    if (nth == 0) w.slot = SLOT_W'(i);
                    nth--;
                end
            end
        end
        held = slot_in_use(w.slot) ? int'(bkt_tokens[w.slot]) : 0;
        case ($urandom_range(4))
            0, 1: w.amount = TOK_W'($urandom_range(held));
            2:    w.amount = TOK_W'(held + 1 + $urandom_range(63));
            3:    w.amount = TOK_W'(held);
            default: ;
        endcase
        case ($urandom_range(4))
            0, 1, 2: begin
                w.rate  = TOK_W'($urandom_range(300));
                w.limit = TOK_W'($urandom_range(2000));
            end
            3: begin
                w.rate  = $urandom_range(1) ? '1 : '0;
                w.limit = $urandom_range(1) ? '1 : '0;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic offer_word(input t_stim_row w);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.cmd    <= w.cmd;
        req_if.slot   <= w.slot;
        req_if.amount <= w.amount;
        req_if.rate   <= w.rate;
        req_if.limit  <= w.limit;
        row_typed     <= w.typed;
        row_want      <= w.want;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
    endtask

    task automatic pause_until_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    initial begin : drive_stimulus
        t_stim_row rows[$];
        req_if.valid  = 1'b0;
        req_if.cmd    = CMD_ALLOC;
        req_if.slot   = '0;
        req_if.amount = '0;
        req_if.rate   = '0;
        req_if.limit  = '0;

        rows.push_back(stim_row(CMD_FETCH, 4'd3, 16'd5, 16'd0, 16'd0,
                                1'b1, ST_FREE, 4'd3, 16'd0));
        rows.push_back(stim_row(CMD_TICK, 4'd15, 16'd0, 16'd0, 16'd0,
                                1'b1, ST_OK, 4'd15, 16'd0));
        rows.push_back(stim_row(CMD_ALLOC, 4'd9, 16'd0, 16'hFFFF, 16'hFFFF,
                                1'b1, ST_OK, 4'd0, 16'd0));
        rows.push_back(stim_row(CMD_ALLOC, 4'd0, 16'd0, 16'd100, 16'd250,
                                1'b1, ST_OK, 4'd1, 16'd0));
        for (int s = 2; s < SLOTS; s++)
            rows.push_back(stim_row(CMD_ALLOC, SLOT_W'(15 - s), 16'hFFFF,
                                    s[0] ? 16'h5555 : 16'hAAAA,
                                    s == SLOTS - 1 ? 16'h0000 : (s[0] ? 16'hAAAA : 16'h5555),
                                    1'b1, ST_OK, SLOT_W'(s), 16'd0));
        // table full
        rows.push_back(stim_row(CMD_ALLOC, 4'd0, 16'd0, 16'hFFFF, 16'hFFFF,
                                1'b1, ST_NOSLOT, 4'd0, 16'd0));
        rows.push_back(stim_row(CMD_FETCH, 4'd0, 16'd1, 16'd0, 16'd0,
                                1'b1, ST_SHORT, 4'd0, 16'd0));
        rows.push_back(stim_row(CMD_TICK, 4'd1, 16'd0, 16'd0, 16'd0,
                                1'b1, ST_OK, 4'd1, 16'd100));
        rows.push_back(stim_row(CMD_TICK, 4'd0, 16'd0, 16'd0, 16'd0,
                                1'b1, ST_OK, 4'd0, 16'hFFFF));
        rows.push_back(stim_row(CMD_TICK, 4'd1, 16'd0, 16'd0, 16'd0,
                                1'b1, ST_OK, 4'd1, 16'd250));
        rows.push_back(stim_row(CMD_FETCH, 4'd1, 16'd251, 16'd0, 16'd0,
                                1'b1, ST_SHORT, 4'd1, 16'd250));
        rows.push_back(stim_row(CMD_FETCH, 4'd1, 16'd0, 16'd0, 16'd0,
                                1'b1, ST_OK, 4'd1, 16'd250));
        rows.push_back(stim_row(CMD_FETCH, 4'd0, 16'hFFFF, 16'd0, 16'd0,
                                1'b1, ST_OK, 4'd0, 16'd0));
        rows.push_back(stim_row(CMD_RELEASE, 4'd0, 16'd0, 16'd0, 16'd0,
                                1'b1, ST_OK, 4'd0, 16'd0));
        rows.push_back(stim_row(CMD_RELEASE, 4'd0, 16'd0, 16'd0, 16'd0,
                                1'b1, ST_FREE, 4'd0, 16'd0));
        rows.push_back(stim_row(CMD_ALLOC, 4'd7, 16'd0, 16'd7, 16'd30,
                                1'b0, ST_OK, 4'd0, 16'd0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) offer_word(rows[k]);

        for (int phase = 0; phase < 3; phase++) begin
            pause_until_drained();
            tx_idle_pct  = phase == 0 ? 20 : phase == 1 ? 71 : 0;
            rx_idle_pct <= phase == 0 ? 71 : phase == 1 ? 20 : 0;
            for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
                if (phase == 2 && n == 40) holds_asked <= holds_asked + 1;
                offer_word(random_word());
            end
        end

        pause_until_drained();
        repeat (TICK_CYCLES + 6) @(posedge i_clk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("token_bucket_table_top_test OK");
        end else begin
            $display("token_bucket_table_top_test NOT OK");
        end
        $finish;
    end

    initial begin : run_limit
        #20_000_000;
        $display("token_bucket_table_top_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tbt_pkg.sv
rtl/core/tbt_ifs.sv
rtl/core/tbt_alu.sv
rtl/core/token_bucket_table_top.sv
test/token_bucket_table_top_test.sv
